FILE: rtl/core/jpfe_pkg.sv
// Package for the JSON "pid" field extractor.
// Holds the transaction types, parser phases, verdict codes and character constants.
// No dependencies.
package jpfe_pkg;

    localparam int unsigned VALUE_BITS = 31;

    localparam logic [VALUE_BITS-1:0] MAX_VALUE_RESET = VALUE_BITS'(64'd2147483647);

    // Key is quote, p, i, d, quote: the first four bytes sit in the window
    localparam logic [31:0] KEY_HEAD  = 32'h2270_6964;
    localparam logic [7:0]  KEY_TAIL  = 8'h22;
    localparam logic [7:0]  CHR_COLON = 8'h3A;
    localparam logic [7:0]  CHR_SPACE = 8'h20;
    localparam logic [7:0]  CHR_TAB   = 8'h09;
    localparam logic [7:0]  CHR_ZERO  = 8'h30;
    localparam logic [7:0]  CHR_NINE  = 8'h39;

    typedef enum logic [2:0] {
        PH_SEARCH      = 3'd0,
        PH_AFTER_KEY   = 3'd1,
        PH_AFTER_COLON = 3'd2,
        PH_DIGITS      = 3'd3,
        PH_DECIDED     = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        V_OK       = 3'd0,
        V_NO_KEY   = 3'd1,
        V_NO_COLON = 3'd2,
        V_NO_DIGIT = 3'd3,
        V_OVERFLOW = 3'd4,
        V_ZERO     = 3'd5
    } t_verdict;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       body_end;
    } t_in_item;

    typedef struct packed {
        logic [VALUE_BITS-1:0] pid_value;
        t_verdict              verdict;
    } t_out_item;

    // Handshake between the parser and its neighbor stages
    typedef struct packed {
        logic advance;
        logic emit;
    } t_step_ctl;

endpackage

FILE: rtl/core/jpfe_in_stage.sv
// Input register of the extractor: holds one accepted transaction for the parser.
// Depends on jpfe_pkg.
module jpfe_in_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  jpfe_pkg::t_in_item i_in_item,
    input  logic               i_out_free,
    output logic               o_item_valid,
    output jpfe_pkg::t_in_item o_item,
    output jpfe_pkg::t_step_ctl o_ctl
);

    logic               r_valid;
    logic               n_valid;
    jpfe_pkg::t_in_item r_item;
    logic               w_accept;

    // Advance unless the held item produces a result and the output is busy
    always_comb begin
        o_ctl.advance = r_valid && (!r_item.body_end || i_out_free);
        o_ctl.emit    = o_ctl.advance && r_item.body_end;
    end

    assign o_in_stall = r_valid && !o_ctl.advance;
    assign w_accept   = i_in_valid && !o_in_stall;

    // Refill or drain the holding register
    always_comb begin
        n_valid = r_valid;
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (o_ctl.advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_in_item;
        end
    end

    assign o_item_valid = r_valid;
    assign o_item       = r_item;

endmodule

FILE: rtl/core/jpfe_parser.sv
// Parser core: key window, phase tracking and digit accumulation, one byte per cycle when not stalled.
// Depends on jpfe_pkg.
module jpfe_parser (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  jpfe_pkg::t_step_ctl                 i_ctl,
    input  jpfe_pkg::t_in_item                  i_item,
    input  logic [jpfe_pkg::VALUE_BITS-1:0]     i_max_value,
    output jpfe_pkg::t_out_item                 o_result
);

    localparam int unsigned WIDE_BITS = jpfe_pkg::VALUE_BITS + 4;

    jpfe_pkg::t_phase                r_phase;
    jpfe_pkg::t_phase                n_phase;
    logic [31:0]                     r_recent;
    logic [31:0]                     n_recent;
    logic [jpfe_pkg::VALUE_BITS-1:0] r_acc;
    logic [jpfe_pkg::VALUE_BITS-1:0] n_acc;
    jpfe_pkg::t_verdict              r_verdict;
    jpfe_pkg::t_verdict              n_verdict;

    logic                            w_blank;
    logic                            w_digit;
    logic [WIDE_BITS-1:0]            w_sum;
    logic                            w_over;
    logic [7:0]                      w_b;
    jpfe_pkg::t_verdict              w_final;

    assign w_b     = i_item.data_byte;
    assign w_blank = (w_b == jpfe_pkg::CHR_SPACE) || (w_b == jpfe_pkg::CHR_TAB);
    assign w_digit = (w_b >= jpfe_pkg::CHR_ZERO) && (w_b <= jpfe_pkg::CHR_NINE);

    // Exact value*10 + digit, compared against the limit at full width
    assign w_sum = {r_acc, 3'b000} + {2'b00, r_acc, 1'b0}
                 + WIDE_BITS'(w_b - jpfe_pkg::CHR_ZERO);
    assign w_over = w_sum > {4'b0000, i_max_value};

    // Step the phase for one byte
    always_comb begin
        n_phase   = r_phase;
        n_recent  = r_recent;
        n_acc     = r_acc;
        n_verdict = r_verdict;
        unique case (r_phase)
            jpfe_pkg::PH_SEARCH: begin
                if (r_recent == jpfe_pkg::KEY_HEAD && w_b == jpfe_pkg::KEY_TAIL) begin
                    n_phase = jpfe_pkg::PH_AFTER_KEY;
                end
                n_recent = {r_recent[23:0], w_b};
            end
            jpfe_pkg::PH_AFTER_KEY: begin
                if (w_b == jpfe_pkg::CHR_COLON) begin
                    n_phase = jpfe_pkg::PH_AFTER_COLON;
                end else if (!w_blank) begin
                    n_phase   = jpfe_pkg::PH_DECIDED;
                    n_verdict = jpfe_pkg::V_NO_COLON;
                end
            end
            jpfe_pkg::PH_AFTER_COLON, jpfe_pkg::PH_DIGITS: begin
                if (w_digit) begin
                    if (w_over) begin
                        n_phase   = jpfe_pkg::PH_DECIDED;
                        n_verdict = jpfe_pkg::V_OVERFLOW;
                    end else begin
                        n_phase = jpfe_pkg::PH_DIGITS;
                        n_acc   = w_sum[jpfe_pkg::VALUE_BITS-1:0];
                    end
                end else if (r_phase == jpfe_pkg::PH_DIGITS) begin
                    n_phase   = jpfe_pkg::PH_DECIDED;
                    n_verdict = (r_acc == '0) ? jpfe_pkg::V_ZERO : jpfe_pkg::V_OK;
                end else if (!w_blank) begin
                    n_phase   = jpfe_pkg::PH_DECIDED;
                    n_verdict = jpfe_pkg::V_NO_DIGIT;
                end
            end
            default: begin
            end
        endcase
    end

    // Map the phase after this byte to the final verdict
    always_comb begin
        unique case (n_phase)
            jpfe_pkg::PH_SEARCH:      w_final = jpfe_pkg::V_NO_KEY;
            jpfe_pkg::PH_AFTER_KEY:   w_final = jpfe_pkg::V_NO_COLON;
            jpfe_pkg::PH_AFTER_COLON: w_final = jpfe_pkg::V_NO_DIGIT;
            jpfe_pkg::PH_DIGITS:      w_final = (n_acc == '0) ? jpfe_pkg::V_ZERO
                                                              : jpfe_pkg::V_OK;
            default:                  w_final = n_verdict;
        endcase
        o_result.verdict   = w_final;
        o_result.pid_value = (w_final == jpfe_pkg::V_OK) ? n_acc : '0;
    end

    // Update state on advance; clear after the final byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.emit) begin
            r_phase   <= jpfe_pkg::PH_SEARCH;
            r_recent  <= '0;
            r_acc     <= '0;
            r_verdict <= jpfe_pkg::V_OK;
        end else if (i_ctl.advance) begin
            r_phase   <= n_phase;
            r_recent  <= n_recent;
            r_acc     <= n_acc;
            r_verdict <= n_verdict;
        end
    end

endmodule

FILE: rtl/core/jpfe_out_stage.sv
// Output register of the extractor: holds one result transaction until taken.
// Depends on jpfe_pkg.
module jpfe_out_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  jpfe_pkg::t_step_ctl  i_ctl,
    input  jpfe_pkg::t_out_item  i_result,
    output logic                 o_out_free,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output jpfe_pkg::t_out_item  o_out_item
);

    logic                r_valid;
    logic                n_valid;
    jpfe_pkg::t_out_item r_item;

    assign o_out_free = !r_valid || !i_out_stall;

    // Load a new result or drop the one just taken
    always_comb begin
        n_valid = r_valid;
        if (i_ctl.emit) begin
            n_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.emit) begin
            r_item <= i_result;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_item  = r_item;

endmodule

FILE: rtl/core/json_pid_field_extractor_unit.sv
// Top level of the JSON "pid" field extractor.
// Depends on jpfe_pkg, jpfe_in_stage, jpfe_parser and jpfe_out_stage.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_item) carries one body byte
//   per transaction, with body_end set on the last byte of a body.
//   Output channel (o_out_valid / i_out_stall / o_out_item) carries one result
//   per body: the parsed pid and a verdict code, produced on the last byte.
//   Configuration channel (i_cfg_valid / o_cfg_ready / i_cfg_data) writes the
//   max_value limit; ready is always high. Write it only between bodies.
// Timing:
//   A byte is registered at acceptance and parsed from the input register; a
//   result is registered in the output register when its last byte is parsed.
//   Throughput is one byte per cycle unless a final byte waits on a stall;
//   the parser step (window compare, value*10+digit add/compare) is combinational.
// Reset:
//   Synchronous active-low reset empties both registers, returns the parser
//   to key search and sets max_value to 2^31-1.
// Backpressure:
//   While a result waits under i_out_stall, non-final bytes keep flowing; a
//   final byte is held in the input register and o_in_stall rises.
module json_pid_field_extractor_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  jpfe_pkg::t_in_item               i_in_item,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output jpfe_pkg::t_out_item              o_out_item,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [jpfe_pkg::VALUE_BITS-1:0]  i_cfg_data
);

    logic [jpfe_pkg::VALUE_BITS-1:0] r_max_value;
    logic                            w_out_free;
    logic                            w_item_valid;
    jpfe_pkg::t_in_item              w_item;
    jpfe_pkg::t_step_ctl             w_ctl;
    jpfe_pkg::t_out_item             w_result;

    // Hold the limit register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_value <= jpfe_pkg::MAX_VALUE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max_value <= i_cfg_data;
        end
    end

    jpfe_in_stage u_in_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_item    (i_in_item),
        .i_out_free   (w_out_free),
        .o_item_valid (w_item_valid),
        .o_item       (w_item),
        .o_ctl        (w_ctl)
    );

    jpfe_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_item      (w_item),
        .i_max_value (r_max_value),
        .o_result    (w_result)
    );

    jpfe_out_stage u_out_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_result    (w_result),
        .o_out_free  (w_out_free),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    // A result is never written over one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.emit |-> (!o_out_valid || !i_out_stall))
        else $error("result register overwritten while stalled");

    // The parser only steps on a held item
    a_advance_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.advance |-> w_item_valid)
        else $error("parser advanced without an item");

    // A failed parse reports no value
    a_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.verdict != jpfe_pkg::V_OK)
            |-> (o_out_item.pid_value == '0))
        else $error("nonzero value with failing verdict");

    // Every emitted result is shown on the next cycle
    a_emit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.emit |=> o_out_valid)
        else $error("emitted result not presented");

endmodule
